/* design/sbu_pkg.sv */
package sbu_pkg;

    localparam int SBU_COORD_BITS   = 24;
    localparam int SBU_CORDIC_STEPS = 18;
    localparam int SBU_GUARD_BITS   = 16;
    localparam int SBU_LEN_W        = SBU_COORD_BITS + 1;
    localparam int SBU_ANGLE_W      = 16;
    localparam int SBU_XY_W         = SBU_COORD_BITS + SBU_GUARD_BITS + 4;
    localparam int SBU_HI_W         = SBU_XY_W - 1 - 24;
    localparam int SBU_Z_W          = 32;
    localparam int SBU_QUEUE_DEPTH  = 2;

    localparam logic signed [SBU_Z_W-1:0] SBU_DEG90  = 32'sd94371840;
    localparam logic signed [SBU_Z_W-1:0] SBU_DEG180 = 32'sd188743680;
    localparam logic signed [SBU_Z_W-1:0] SBU_ANGLE_LIMIT = 32'sd23040;

    typedef enum logic [1:0] {
        QUAD_NONE  = 2'd0,
        QUAD_POS90 = 2'd1,
        QUAD_NEG90 = 2'd2
    } sbu_quad_t;

    typedef struct packed {
        logic signed [SBU_COORD_BITS-1:0] point_x;
        logic signed [SBU_COORD_BITS-1:0] point_y;
        logic                             start_of_path;
    } sbu_item_t;

    typedef struct packed {
        logic [SBU_LEN_W-1:0]          segment_length;
        logic signed [SBU_ANGLE_W-1:0] segment_angle;
    } sbu_result_t;

    typedef struct packed {
        logic                           zero;
        sbu_quad_t                      quad;
        logic signed [SBU_COORD_BITS:0] rot_x;
        logic signed [SBU_COORD_BITS:0] rot_y;
    } sbu_job_t;

    function automatic logic [31:0] sbu_gain(input int steps);
        logic [63:0] tail;
        tail = 64'd1738754331 >> (2 * steps);
        return 32'(64'd2608131496 + tail);
    endfunction

    function automatic logic signed [SBU_Z_W-1:0] sbu_atan(input logic [4:0] i);
        logic signed [SBU_Z_W-1:0] a;
        case (i)
            5'd0:    a = 32'sd47185920;
            5'd1:    a = 32'sd27855475;
            5'd2:    a = 32'sd14718068;
            5'd3:    a = 32'sd7471121;
            5'd4:    a = 32'sd3750058;
            5'd5:    a = 32'sd1876857;
            5'd6:    a = 32'sd938658;
            5'd7:    a = 32'sd469357;
            5'd8:    a = 32'sd234682;
            5'd9:    a = 32'sd117342;
            5'd10:   a = 32'sd58671;
            5'd11:   a = 32'sd29335;
            5'd12:   a = 32'sd14668;
            5'd13:   a = 32'sd7334;
            5'd14:   a = 32'sd3667;
            5'd15:   a = 32'sd1833;
            5'd16:   a = 32'sd917;
            5'd17:   a = 32'sd458;
            5'd18:   a = 32'sd229;
            5'd19:   a = 32'sd115;
            5'd20:   a = 32'sd57;
            5'd21:   a = 32'sd29;
            5'd22:   a = 32'sd14;
            5'd23:   a = 32'sd7;
            5'd24:   a = 32'sd4;
            5'd25:   a = 32'sd2;
            5'd26:   a = 32'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

/* design/segment_length_and_bearing_unit.sv */
// Segment length and bearing unit.
// Input queue port: push/full carry one point transaction (point_x, point_y,
// start_of_path). A point with start_of_path set, or the first point after
// reset, only becomes the new previous point and yields no result. Every
// other point yields one result: the distance from the previous point and
// the bearing atan2(dy, dx) in degrees with 7 fraction bits.
// Result queue port: a result is on the result ports while empty is low and
// is taken by pop.
// Flow: a point is classified in the cycle it is taken and enters a
// two-entry job queue; the vectoring unit then takes each segment through a
// load step, CORDIC_STEPS rotations, a gain multiply and a rounding step.
// A zero-length segment goes from the load step straight to the last step.
// The vectoring unit takes a new job only after it has finished the last
// one, as it has a single shared rotation datapath.
// Stall: a held result blocks the vectoring unit at its last stage, the job
// queue then fills, and full rises. Reset empties both queues and forgets
// the previous point.
module segment_length_and_bearing_unit
    import sbu_pkg::*;
#(
    parameter int CORDIC_STEPS = SBU_CORDIC_STEPS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  sbu_item_t   item,
    output logic        full,
    input  logic        pop,
    output logic        empty,
    output sbu_result_t result
);

    logic     q_full;
    logic     q_push;
    sbu_job_t q_wjob;
    logic     q_empty;
    logic     q_pop;
    sbu_job_t q_rjob;

    sbu_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .q_full (q_full),
        .q_push (q_push),
        .q_job  (q_wjob)
    );

    sbu_queue #(
        .WIDTH ($bits(sbu_job_t)),
        .DEPTH (SBU_QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wjob),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rjob),
        .empty (q_empty)
    );

    sbu_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!q_empty),
        .job       (q_rjob),
        .job_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

/* design/sbu_front.sv */
module sbu_front
    import sbu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  sbu_item_t item,
    output logic      full,
    input  logic      q_full,
    output logic      q_push,
    output sbu_job_t  q_job
);

    logic signed [SBU_COORD_BITS-1:0] prev_x_reg, prev_x_next;
    logic signed [SBU_COORD_BITS-1:0] prev_y_reg, prev_y_next;
    logic                             have_prev_reg, have_prev_next;
    logic                             accept;
    logic signed [SBU_COORD_BITS:0]   dx;
    logic signed [SBU_COORD_BITS:0]   dy;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign dx     = (SBU_COORD_BITS+1)'(item.point_x) - (SBU_COORD_BITS+1)'(prev_x_reg);
    assign dy     = (SBU_COORD_BITS+1)'(item.point_y) - (SBU_COORD_BITS+1)'(prev_y_reg);
    assign q_push = accept && !item.start_of_path && have_prev_reg;

    always_comb
    begin
        q_job.zero = (dx == '0) && (dy == '0);
        if (!dx[SBU_COORD_BITS])
        begin
            q_job.quad  = QUAD_NONE;
            q_job.rot_x = dx;
            q_job.rot_y = dy;
        end
        else if (!dy[SBU_COORD_BITS])
        begin
            q_job.quad  = QUAD_POS90;
            q_job.rot_x = dy;
            q_job.rot_y = -dx;
        end
        else
        begin
            q_job.quad  = QUAD_NEG90;
            q_job.rot_x = -dy;
            q_job.rot_y = dx;
        end
    end

    always_comb
    begin
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        have_prev_next = have_prev_reg;
        if (accept)
        begin
            prev_x_next    = item.point_x;
            prev_y_next    = item.point_y;
            have_prev_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            have_prev_reg <= have_prev_next;
        end
    end

endmodule

/* design/sbu_queue.sv */
module sbu_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rdata   = mem_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

/* design/sbu_back.sv */
module sbu_back
    import sbu_pkg::*;
#(
    parameter int CORDIC_STEPS = SBU_CORDIC_STEPS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    input  sbu_job_t    job,
    output logic        job_pop,
    output logic        empty,
    input  logic        pop,
    output sbu_result_t result
);

    localparam int STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int IW    = $clog2(STEPS);
    localparam logic [31:0] GAIN = sbu_gain(STEPS);
    localparam int PH_W  = SBU_HI_W + 32;
    localparam int PL_W  = 24 + 32;
    localparam int T_W   = PH_W + 2;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ROTATE = 4'b0010,
        ST_SCALE  = 4'b0100,
        ST_FINISH = 4'b1000
    } sbu_state_t;

    sbu_state_t                  state_reg, state_next;
    logic [IW-1:0]               cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;
    logic signed [SBU_XY_W-1:0]  x_reg, x_next;
    logic signed [SBU_XY_W-1:0]  y_reg, y_next;
    logic signed [SBU_Z_W-1:0]   z_reg, z_next;
    logic                        zero_reg, zero_next;
    logic [PH_W-1:0]             prod_h_reg, prod_h_next;
    logic [PL_W-1:0]             prod_l_reg, prod_l_next;
    sbu_result_t                 out_reg, out_next;

    logic signed [SBU_XY_W-1:0]  xs;
    logic signed [SBU_XY_W-1:0]  ys;
    logic signed [SBU_Z_W-1:0]   step_angle;
    logic [SBU_XY_W-2:0]         ux;
    logic [T_W-1:0]              t_sum;
    logic [T_W-25:0]             len_wide;
    logic [SBU_LEN_W-1:0]        len;
    logic signed [SBU_Z_W-1:0]   z_clamp;
    logic signed [SBU_Z_W-1:0]   z_round;
    logic signed [SBU_Z_W-1:0]   ang_wide;
    logic signed [SBU_Z_W-1:0]   ang_clamp;
    logic                        out_free;

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    assign xs         = x_reg >>> cnt_reg;
    assign ys         = y_reg >>> cnt_reg;
    assign step_angle = sbu_atan(5'(cnt_reg));

    assign ux          = x_reg[SBU_XY_W-1] ? '0 : x_reg[SBU_XY_W-2:0];
    assign prod_h_next = ux[SBU_XY_W-2:24] * GAIN;
    assign prod_l_next = ux[23:0] * GAIN;

    assign t_sum    = T_W'(prod_h_reg) + T_W'(prod_l_reg[PL_W-1:24]) + T_W'(24'h800000);
    assign len_wide = t_sum[T_W-1:24];
    assign len      = (len_wide > (T_W-24)'({SBU_LEN_W{1'b1}})) ? {SBU_LEN_W{1'b1}}
                                                               : len_wide[SBU_LEN_W-1:0];

    assign z_clamp   = (z_reg > SBU_DEG180) ? SBU_DEG180 :
                       (z_reg < -SBU_DEG180) ? -SBU_DEG180 : z_reg;
    assign z_round   = z_clamp + 32'sd4096;
    assign ang_wide  = z_round >>> 13;
    assign ang_clamp = (ang_wide > SBU_ANGLE_LIMIT) ? SBU_ANGLE_LIMIT :
                       (ang_wide < -SBU_ANGLE_LIMIT) ? -SBU_ANGLE_LIMIT : ang_wide;

    assign out_free = !out_valid_reg || pop;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !pop;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        zero_next      = zero_reg;
        out_next       = out_reg;
        job_pop        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop   = 1'b1;
                    zero_next = job.zero;
                    cnt_next  = '0;
                    x_next    = SBU_XY_W'(job.rot_x) <<< SBU_GUARD_BITS;
                    y_next    = SBU_XY_W'(job.rot_y) <<< SBU_GUARD_BITS;
                    case (job.quad)
                        QUAD_POS90: z_next = SBU_DEG90;
                        QUAD_NEG90: z_next = -SBU_DEG90;
                        default:    z_next = '0;
                    endcase
                    state_next = job.zero ? ST_FINISH : ST_ROTATE;
                end
            end
            ST_ROTATE:
            begin
                if (!y_reg[SBU_XY_W-1])
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + step_angle;
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - step_angle;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == IW'(STEPS - 1))
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (zero_reg)
                    begin
                        out_next.segment_length = '0;
                        out_next.segment_angle  = '0;
                    end
                    else
                    begin
                        out_next.segment_length = len;
                        out_next.segment_angle  = ang_clamp[SBU_ANGLE_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        zero_reg   <= zero_next;
        out_reg    <= out_next;
        if (state_reg == ST_SCALE)
        begin
            prod_h_reg <= prod_h_next;
            prod_l_reg <= prod_l_next;
        end
    end

endmodule

/* design/sbu_checker.sv */
module sbu_checker
    import sbu_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input sbu_item_t   item,
    input logic        pop,
    input logic        empty,
    input sbu_result_t result
);

    a_empty_in_reset: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result queue not empty during reset");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("waiting result changed or vanished");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ($signed(result.segment_angle) <= 16'sd23040) &&
                   ($signed(result.segment_angle) >= -16'sd23040))
        else $error("bearing out of range");

    a_zero_length: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (result.segment_length == '0) |-> (result.segment_angle == '0))
        else $error("zero-length segment with nonzero bearing");

    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !$isunknown(result))
        else $error("waiting result has unknown bits");

endmodule

bind segment_length_and_bearing_unit sbu_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .item   (item),
    .pop    (pop),
    .empty  (empty),
    .result (result)
);

/* dv/sbu_checker.sv */
module sbu_tb_checker
    import sbu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  sbu_item_t   item,
    input  logic        full,
    input  logic        pop,
    input  logic        empty,
    input  sbu_result_t result,
    output int          mismatches,
    output int          results_checked,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned LEN_MAX = (64'd1 << SBU_LEN_W) - 1;
    localparam int REPORT_LIMIT = 10;

    sbu_result_t pending_segments[$];
    longint      prev_x;
    longint      prev_y;
    bit          have_prev;

    function automatic longint atan_step_deg(input int i);
        longint a;
        case (i)
            0:       a = 47185920;
            1:       a = 27855475;
            2:       a = 14718068;
            3:       a = 7471121;
            4:       a = 3750058;
            5:       a = 1876857;
            6:       a = 938658;
            7:       a = 469357;
            8:       a = 234682;
            9:       a = 117342;
            10:      a = 58671;
            11:      a = 29335;
            12:      a = 14668;
            13:      a = 7334;
            14:      a = 3667;
            15:      a = 1833;
            16:      a = 917;
            17:      a = 458;
            18:      a = 229;
            19:      a = 115;
            20:      a = 57;
            21:      a = 29;
            22:      a = 14;
            23:      a = 7;
            24:      a = 4;
            25:      a = 2;
            26:      a = 1;
            default: a = 0;
        endcase
        return a;
    endfunction

    function automatic sbu_result_t length_and_bearing(input longint dx, input longint dy);
        longint          x;
        longint          y;
        longint          z;
        longint          xs;
        longint          ys;
        longint          ang;
        longint unsigned gain;
        longint unsigned ux;
        longint unsigned t;
        longint unsigned len;
        sbu_result_t     r;
        int              i;
        r = '0;
        if (dx == 0 && dy == 0)
        begin
            return r;
        end
        // pre-rotate into the right half plane
        if (dx >= 0)
        begin
            x = dx;
            y = dy;
            z = 0;
        end
        else if (dy >= 0)
        begin
            x = dy;
            y = -dx;
            z = SBU_DEG90;
        end
        else
        begin
            x = -dy;
            y = dx;
            z = -longint'(SBU_DEG90);
        end
        x = x * 65536;
        y = y * 65536;
        for (i = 0; i < SBU_CORDIC_STEPS && i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_step_deg(i);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_step_deg(i);
            end
        end
        gain = 64'd2608131496;
        if (2 * SBU_CORDIC_STEPS < 64)
        begin
            gain = gain + (64'd1738754331 >> (2 * SBU_CORDIC_STEPS));
        end
        ux = (x < 0) ? 64'd0 : longint'(x);
        t = (ux >> 24) * gain + (((ux & 64'hFFFFFF) * gain) >> 24);
        len = (t + (64'd1 << 23)) >> 24;
        if (len > LEN_MAX)
        begin
            len = LEN_MAX;
        end
        if (z > longint'(SBU_DEG180))
        begin
            z = SBU_DEG180;
        end
        if (z < -longint'(SBU_DEG180))
        begin
            z = -longint'(SBU_DEG180);
        end
        ang = (z + longint'(4096)) >>> 13;
        if (ang > longint'(SBU_ANGLE_LIMIT))
        begin
            ang = SBU_ANGLE_LIMIT;
        end
        if (ang < -longint'(SBU_ANGLE_LIMIT))
        begin
            ang = -longint'(SBU_ANGLE_LIMIT);
        end
        r.segment_length = len[SBU_LEN_W-1:0];
        r.segment_angle  = ang[SBU_ANGLE_W-1:0];
        return r;
    endfunction

    task automatic report_field(input string field, input longint want, input longint got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("%0t: mismatch on %s: expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sbu_result_t want;
        longint      px;
        longint      py;
        if (!rst_n)
        begin
            pending_segments.delete();
            prev_x = 0;
            prev_y = 0;
            have_prev = 1'b0;
            mismatches = 0;
            results_checked = 0;
            outstanding = 0;
        end
        else
        begin
            // check the popped result before the new transaction: it is always older
            if (pop && !empty)
            begin
                results_checked++;
                if (pending_segments.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("%0t: unexpected result: length %0d, angle %0d", $time,
                                 result.segment_length, result.segment_angle);
                    end
                end
                else
                begin
                    want = pending_segments.pop_front();
                    if (result.segment_length !== want.segment_length)
                    begin
                        report_field("segment_length", want.segment_length,
                                     result.segment_length);
                    end
                    if (result.segment_angle !== want.segment_angle)
                    begin
                        report_field("segment_angle", want.segment_angle,
                                     result.segment_angle);
                    end
                end
            end
            if (push && !full)
            begin
                px = item.point_x;
                py = item.point_y;
                if (item.start_of_path || !have_prev)
                begin
                    have_prev = 1'b1;
                end
                else
                begin
                    pending_segments.push_back(length_and_bearing(px - prev_x, py - prev_y));
                end
                prev_x = px;
                prev_y = py;
            end
            outstanding = pending_segments.size();
        end
    end

endmodule

/* dv/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sbu_pkg::*;

    localparam int POINT_TARGET = 1950;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 60;

    localparam logic signed [SBU_COORD_BITS-1:0] C_MAX = {1'b0, {(SBU_COORD_BITS-1){1'b1}}};
    localparam logic signed [SBU_COORD_BITS-1:0] C_MIN = {1'b1, {(SBU_COORD_BITS-1){1'b0}}};

    logic        clk;
    logic        rst_n;
    logic        push;
    sbu_item_t   item;
    logic        full;
    logic        pop;
    logic        empty;
    sbu_result_t result;

    int mismatches;
    int results_checked;
    int outstanding;
    int points_sent;
    int paths_sent;
    int cycles;
    int pop_hold;
    bit steady;

    logic signed [SBU_COORD_BITS-1:0] cur_x;
    logic signed [SBU_COORD_BITS-1:0] cur_y;

    segment_length_and_bearing_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

    sbu_tb_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .item            (item),
        .full            (full),
        .pop             (pop),
        .empty           (empty),
        .result          (result),
        .mismatches      (mismatches),
        .results_checked (results_checked),
        .outstanding     (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 90)
        begin
            return $urandom_range(4, 9);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [SBU_COORD_BITS-1:0] step_delta();
        int d;
        d = int'($urandom) >>> $urandom_range(7, 31);
        return d[SBU_COORD_BITS-1:0];
    endfunction

    task automatic send_point(input logic signed [SBU_COORD_BITS-1:0] x,
                              input logic signed [SBU_COORD_BITS-1:0] y,
                              input logic start);
        int gap;
        item <= '{point_x: x, point_y: y, start_of_path: start};
        push <= 1'b1;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        points_sent++;
        cur_x = x;
        cur_y = y;
        gap = (!steady && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic random_path();
        int n;
        int kind;
        logic signed [SBU_COORD_BITS-1:0] nx;
        logic signed [SBU_COORD_BITS-1:0] ny;
        paths_sent++;
        steady = ($urandom_range(0, 7) == 0);
        // mostly start a fresh path, sometimes keep going from the last point
        if ($urandom_range(0, 9) != 0)
        begin
            send_point(SBU_COORD_BITS'($urandom), SBU_COORD_BITS'($urandom), 1'b1);
        end
        n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
        repeat (n)
        begin
            kind = $urandom_range(0, 19);
            nx = cur_x;
            ny = cur_y;
            if (kind < 9)
            begin
                nx = cur_x + step_delta();
                ny = cur_y + step_delta();
            end
            else if (kind < 11)
            begin
            end
            else if (kind < 13)
            begin
                if ($urandom_range(0, 1))
                begin
                    nx = cur_x + step_delta();
                end
                else
                begin
                    ny = cur_y + step_delta();
                end
            end
            else if (kind < 18)
            begin
                nx = SBU_COORD_BITS'($urandom);
                ny = SBU_COORD_BITS'($urandom);
            end
            else
            begin
                nx = $urandom_range(0, 1) ? C_MAX : C_MIN;
                ny = $urandom_range(0, 1) ? C_MAX : C_MIN;
            end
            // an occasional stray start flag breaks the path
            send_point(nx, ny, $urandom_range(0, 29) == 0);
        end
    endtask

    initial
    begin
        pop = 1'b0;
        pop_hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop_hold > 0)
            begin
                pop <= 1'b0;
                pop_hold--;
            end
            else
            begin
                pop <= 1'b1;
                if (!steady && $urandom_range(0, 4) == 0)
                begin
                    pop_hold = idle_len();
                end
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Run timed out after %0d cycles, %0d results still due", cycles, outstanding);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        points_sent = 0;
        paths_sent = 0;
        steady = 1'b0;
        cur_x = '0;
        cur_y = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_point('0, '0, 1'b0);
        send_point('0, '0, 1'b0);
        send_point(C_MAX, '0, 1'b0);
        send_point(C_MAX, C_MAX, 1'b0);
        send_point(C_MIN, C_MAX, 1'b0);
        send_point(C_MIN, C_MIN, 1'b0);
        send_point(C_MAX, C_MAX, 1'b0);
        send_point(C_MIN, C_MIN, 1'b0);
        send_point(C_MIN, C_MAX, 1'b0);
        send_point(C_MAX, C_MIN, 1'b0);
        send_point(C_MIN, C_MAX, 1'b0);
        send_point(C_MIN + 24'sd1, C_MAX, 1'b0);
        send_point(C_MIN + 24'sd1, C_MAX - 24'sd1, 1'b0);
        send_point(C_MIN, C_MAX - 24'sd1, 1'b0);
        send_point(C_MIN + 24'sd1, C_MAX, 1'b0);
        send_point(24'sd100, 24'sd200, 1'b1);
        send_point(24'sd100, 24'sd200, 1'b1);
        send_point(-24'sd300, 24'sd50, 1'b0);
        send_point(-24'sd300, 24'sd50, 1'b0);
        send_point(-24'sd301, -24'sd50, 1'b0);
        send_point(24'sd5000, -24'sd1, 1'b0);
        send_point(-24'sd1, -24'sd1, 1'b1);
        send_point(24'sd0, 24'sd0, 1'b0);

        while (points_sent < POINT_TARGET)
        begin
            random_path();
        end
        push <= 1'b0;
        steady = 1'b0;

        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d points over %0d random paths plus a directed set", points_sent,
                 paths_sent);
        $display("Checked %0d segment results in %0d cycles", results_checked, cycles);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
